FILE: hw/rtl/avkf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avkf_pkg
// Shared types, codes and helpers of the altitude and vertical-speed filter.
// ----------------------------------------------------------------------------
package avkf_pkg;

    localparam int DATA_W          = 32;
    localparam int ACC_W           = 68;
    localparam int MUL_W           = 33;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MIN_UPDATES_DEF = 20;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 31;
    localparam int NOISE_W         = 24;
    localparam int LIMIT_W         = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_ALT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SPD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_BARO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER   = 2'd3;

    localparam logic [1:0] MODE_PREDICT = 2'd0;
    localparam logic [1:0] MODE_BARO    = 2'd1;
    localparam logic [1:0] MODE_LOAD    = 2'd2;

    localparam logic [1:0] ST_APPLIED   = 2'd0;
    localparam logic [1:0] ST_DT_BAD    = 2'd1;
    localparam logic [1:0] ST_OUTLIER   = 2'd2;
    localparam logic [1:0] ST_S_SMALL   = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] accel;
        logic [16:0]        time_step;
        logic signed [31:0] baro_altitude;
        logic signed [31:0] set_altitude;
        logic signed [31:0] set_speed;
    } avkf_in_t;

    typedef struct packed {
        logic signed [31:0] altitude;
        logic signed [31:0] speed;
        logic signed [31:0] innovation;
        logic signed [31:0] altitude_variance;
        logic signed [31:0] speed_variance;
        logic               converged;
        logic [1:0]         status;
    } avkf_out_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = -ACC_W'(64'sh8000_0000);
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < lo) begin
            return 32'sh8000_0000;
        end
        else begin
            return x[DATA_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/avkf_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avkf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module avkf_mul #(
    parameter int W = 33
) (
    input  wire logic                  clk,
    input  wire logic signed [W-1:0]   a,
    input  wire logic signed [W-1:0]   b,
    output logic signed [2*W-1:0]      prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/avkf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avkf_div
// Bit-serial restoring divider for the gains: (num * 2^FRAC_BITS) / den,
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module avkf_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [31:0]         num,
    input  wire logic [32:0]                den,
    output logic                            done_reg,
    output logic signed [32+FRAC_BITS:0]    quot
);

    localparam int NUMW  = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUMW + 1);

    logic [NUMW-1:0]  quo_reg;
    logic [32:0]      rem_reg;
    logic [32:0]      den_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [33:0]      rem_sh;
    logic [33:0]      rem_diff;
    logic [31:0]      num_mag;

    assign num_mag  = num[31] ? 32'(-num) : 32'(num);
    assign rem_sh   = {rem_reg, quo_reg[NUMW-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign quot     = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUMW);
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            quo_reg <= {num_mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[31];
        end
        else if (busy_reg) begin
            if (!rem_diff[33]) begin
                rem_reg <= rem_diff[32:0];
                quo_reg <= {quo_reg[NUMW-2:0], 1'b1};
            end
            else begin
                rem_reg <= rem_sh[32:0];
                quo_reg <= {quo_reg[NUMW-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/altitude_vario_kalman_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// altitude_vario_kalman_filter
// Two-state altitude and vertical-speed Kalman filter in signed fixed point.
//
// One request on the input channel carries a mode: predict, barometer update
// or state load. Each request gives exactly one result with the state after
// it and a status code. Configuration registers are written through a plain
// write port; the user must write them only while the block is idle, as the
// block itself does not enforce it. The multiplies share one registered
// multiplier, and a barometer update runs the bit-serial gain divider twice.
// A load, an unused mode or a bad time step goes straight to the result, and
// a rejected barometer update ends after its check. in_ready rises together
// with the result. The block takes one request at a time; in_ready is high
// when the sequencer is idle, also while a result waits. A finished result
// waits in its own state until the output register is free, so a stalled
// receiver holds back the next request. Reset loads the default registers,
// zero state and the initial covariance.
// ----------------------------------------------------------------------------
module altitude_vario_kalman_filter #(
    parameter int FRAC_BITS   = avkf_pkg::FRAC_BITS_DEF,
    parameter int MIN_UPDATES = avkf_pkg::MIN_UPDATES_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire avkf_pkg::avkf_in_t                    in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output avkf_pkg::avkf_out_t                        out_data,
    input  wire logic                                  cfg_write,
    input  wire logic [avkf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [avkf_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import avkf_pkg::*;

    localparam longint ONE_FX = 64'sd1 <<< FRAC_BITS;
    localparam longint DT_MIN = (ONE_FX + 999) / 1000;
    localparam longint S_MIN  = (ONE_FX + 9999) / 10000;
    localparam longint AA_RAW = 100 * ONE_FX;
    localparam longint AA_INI = (AA_RAW > 64'sd2147483647) ? 64'sd2147483647 : AA_RAW;
    localparam longint SS_RAW = 10 * ONE_FX;
    localparam longint SS_INI = (SS_RAW > 64'sd2147483647) ? 64'sd2147483647 : SS_RAW;
    localparam longint PNA_INI = (ONE_FX + 50) / 100;
    localparam longint PNS_INI = (ONE_FX + 5) / 10;
    localparam longint BN_INI  = ONE_FX / 2;
    localparam longint OL_INI  = 50 * ONE_FX;
    localparam int     CNT_W   = 5;
    localparam int     QW      = 33 + FRAC_BITS;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_P0   = 5'd1;
    localparam logic [4:0] S_P1   = 5'd2;
    localparam logic [4:0] S_P2   = 5'd3;
    localparam logic [4:0] S_P3   = 5'd4;
    localparam logic [4:0] S_P4   = 5'd5;
    localparam logic [4:0] S_P5   = 5'd6;
    localparam logic [4:0] S_P6   = 5'd7;
    localparam logic [4:0] S_P7   = 5'd8;
    localparam logic [4:0] S_U0   = 5'd9;
    localparam logic [4:0] S_UD0  = 5'd10;
    localparam logic [4:0] S_UD1  = 5'd11;
    localparam logic [4:0] S_M0   = 5'd12;
    localparam logic [4:0] S_M1   = 5'd13;
    localparam logic [4:0] S_M2   = 5'd14;
    localparam logic [4:0] S_M3   = 5'd15;
    localparam logic [4:0] S_M4   = 5'd16;
    localparam logic [4:0] S_M5   = 5'd17;
    localparam logic [4:0] S_M6   = 5'd18;
    localparam logic [4:0] S_FIN  = 5'd19;

    logic [4:0]               state_reg;
    avkf_in_t                 item_reg;
    logic [NOISE_W-1:0]       pna_reg;
    logic [NOISE_W-1:0]       pns_reg;
    logic [NOISE_W-1:0]       bn_reg;
    logic [LIMIT_W-1:0]       ol_reg;
    logic signed [31:0]       alt_reg;
    logic signed [31:0]       spd_reg;
    logic signed [31:0]       aa_reg;
    logic signed [31:0]       as_reg;
    logic signed [31:0]       sa_reg;
    logic signed [31:0]       ss_reg;
    logic signed [31:0]       innov_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     conv_reg;
    logic [1:0]               status_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [MUL_W-1:0]  dt2_reg;
    logic signed [31:0]       k0_reg;
    logic signed [31:0]       k1_reg;
    logic signed [31:0]       naa_reg;
    logic signed [31:0]       nas_reg;
    logic signed [31:0]       nsa_reg;
    logic [32:0]              s_reg;
    logic                     out_valid_reg;
    avkf_out_t                out_reg;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   prod_sh;
    logic                      div_start;
    logic signed [31:0]        div_num;
    logic [32:0]               div_den;
    logic                      div_done;
    logic signed [QW-1:0]      div_quot;

    logic signed [MUL_W-1:0]   dt_x;
    logic signed [MUL_W-1:0]   dt2x_x;
    logic signed [MUL_W-1:0]   omk0;
    logic signed [ACC_W-1:0]   innov_w;
    logic signed [31:0]        innov_n;
    logic signed [ACC_W-1:0]   mag_w;
    logic signed [ACC_W-1:0]   s_w;
    logic [CNT_W-1:0]          cnt_n;
    logic                      dt_bad;
    logic                      accept;
    logic                      out_load;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign dt_x   = $signed({{(MUL_W-17){1'b0}}, item_reg.time_step});
    assign dt2x_x = $signed({{(MUL_W-18){1'b0}}, item_reg.time_step, 1'b0});
    assign omk0   = MUL_W'(ONE_FX) - MUL_W'(k0_reg);
    assign prod_sh = ACC_W'(prod_reg >>> FRAC_BITS);
    assign dt_bad = (longint'(in_data.time_step) < DT_MIN) ||
                    (longint'(in_data.time_step) > ONE_FX);

    assign innov_w = ACC_W'(item_reg.baro_altitude) - ACC_W'(alt_reg);
    assign innov_n = sat32(innov_w);
    assign mag_w   = innov_n[31] ? -ACC_W'(innov_n) : ACC_W'(innov_n);
    assign s_w     = ACC_W'(aa_reg) + $signed({{(ACC_W-NOISE_W){1'b0}}, bn_reg});
    assign cnt_n   = (cnt_reg < CNT_W'(MIN_UPDATES + 1)) ? cnt_reg + 1'b1 : cnt_reg;

    avkf_mul #(
        .W (MUL_W)
    ) u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    avkf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done_reg (div_done),
        .quot     (div_quot)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_P0:
            begin
                mul_a = MUL_W'(spd_reg);
                mul_b = dt_x;
            end
            S_P1:
            begin
                mul_a = MUL_W'(item_reg.accel);
                mul_b = dt_x;
            end
            S_P2:
            begin
                mul_a = dt2x_x;
                mul_b = MUL_W'(as_reg);
            end
            S_P3:
            begin
                mul_a = dt_x;
                mul_b = dt_x;
            end
            S_P5:
            begin
                mul_a = dt2_reg;
                mul_b = MUL_W'(ss_reg);
            end
            S_P6:
            begin
                mul_a = dt_x;
                mul_b = MUL_W'(ss_reg);
            end
            S_M0:
            begin
                mul_a = MUL_W'(k0_reg);
                mul_b = MUL_W'(innov_reg);
            end
            S_M1:
            begin
                mul_a = MUL_W'(k1_reg);
                mul_b = MUL_W'(innov_reg);
            end
            S_M2:
            begin
                mul_a = omk0;
                mul_b = MUL_W'(aa_reg);
            end
            S_M3:
            begin
                mul_a = omk0;
                mul_b = MUL_W'(as_reg);
            end
            S_M4:
            begin
                mul_a = MUL_W'(k1_reg);
                mul_b = MUL_W'(aa_reg);
            end
            S_M5:
            begin
                mul_a = MUL_W'(k1_reg);
                mul_b = MUL_W'(as_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = aa_reg;
        div_den   = s_reg;
        if (state_reg == S_U0) begin
            div_start = !(mag_w > ACC_W'(ol_reg)) && !(s_w < ACC_W'(S_MIN));
            div_den   = s_w[32:0];
        end
        else if (state_reg == S_UD0 && div_done) begin
            div_start = 1'b1;
            div_num   = sa_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pna_reg       <= NOISE_W'(PNA_INI);
            pns_reg       <= NOISE_W'(PNS_INI);
            bn_reg        <= NOISE_W'(BN_INI);
            ol_reg        <= LIMIT_W'(OL_INI);
            alt_reg       <= '0;
            spd_reg       <= '0;
            aa_reg        <= 32'(AA_INI);
            as_reg        <= '0;
            sa_reg        <= '0;
            ss_reg        <= 32'(SS_INI);
            innov_reg     <= '0;
            cnt_reg       <= '0;
            conv_reg      <= 1'b0;
            status_reg    <= ST_APPLIED;
            acc_reg       <= '0;
            dt2_reg       <= '0;
            k0_reg        <= '0;
            k1_reg        <= '0;
            naa_reg       <= '0;
            nas_reg       <= '0;
            nsa_reg       <= '0;
            s_reg         <= '0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_NOISE_ALT:  pna_reg <= cfg_data[NOISE_W-1:0];
                    CFG_NOISE_SPD:  pns_reg <= cfg_data[NOISE_W-1:0];
                    CFG_NOISE_BARO: bn_reg  <= cfg_data[NOISE_W-1:0];
                    CFG_OUTLIER:    ol_reg  <= cfg_data[LIMIT_W-1:0];
                    default:        ol_reg  <= ol_reg;
                endcase
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept) begin
                        status_reg <= ST_APPLIED;
                        state_reg  <= S_FIN;
                        case (in_data.mode)
                            MODE_PREDICT:
                            begin
                                if (dt_bad) begin
                                    status_reg <= ST_DT_BAD;
                                end
                                else begin
                                    state_reg <= S_P0;
                                end
                            end
                            MODE_BARO:
                            begin
                                state_reg <= S_U0;
                            end
                            MODE_LOAD:
                            begin
                                alt_reg  <= in_data.set_altitude;
                                spd_reg  <= in_data.set_speed;
                                aa_reg   <= 32'(AA_INI);
                                as_reg   <= '0;
                                sa_reg   <= '0;
                                ss_reg   <= 32'(SS_INI);
                                cnt_reg  <= '0;
                                conv_reg <= 1'b0;
                            end
                            default:
                            begin
                                status_reg <= ST_APPLIED;
                            end
                        endcase
                    end
                end
                S_P0: state_reg <= S_P1;
                S_P1:
                begin
                    alt_reg   <= sat32(ACC_W'(alt_reg) + prod_sh);
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    spd_reg   <= sat32(ACC_W'(spd_reg) + prod_sh);
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    acc_reg   <= prod_sh;
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    dt2_reg   <= MUL_W'(prod_reg >>> FRAC_BITS);
                    state_reg <= S_P5;
                end
                S_P5: state_reg <= S_P6;
                S_P6:
                begin
                    acc_reg   <= acc_reg + prod_sh;
                    state_reg <= S_P7;
                end
                S_P7:
                begin
                    as_reg    <= sat32(ACC_W'(as_reg) + prod_sh);
                    sa_reg    <= sat32(ACC_W'(sa_reg) + prod_sh);
                    aa_reg    <= sat32(ACC_W'(aa_reg) + acc_reg +
                                       $signed({{(ACC_W-NOISE_W){1'b0}}, pna_reg}));
                    ss_reg    <= sat32(ACC_W'(ss_reg) +
                                       $signed({{(ACC_W-NOISE_W){1'b0}}, pns_reg}));
                    state_reg <= S_FIN;
                end
                S_U0:
                begin
                    innov_reg <= innov_n;
                    s_reg     <= s_w[32:0];
                    if (mag_w > ACC_W'(ol_reg)) begin
                        status_reg <= ST_OUTLIER;
                        state_reg  <= S_FIN;
                    end
                    else if (s_w < ACC_W'(S_MIN)) begin
                        status_reg <= ST_S_SMALL;
                        state_reg  <= S_FIN;
                    end
                    else begin
                        state_reg <= S_UD0;
                    end
                end
                S_UD0:
                begin
                    if (div_done) begin
                        k0_reg    <= sat32(ACC_W'(div_quot));
                        state_reg <= S_UD1;
                    end
                end
                S_UD1:
                begin
                    if (div_done) begin
                        k1_reg    <= sat32(ACC_W'(div_quot));
                        state_reg <= S_M0;
                    end
                end
                S_M0: state_reg <= S_M1;
                S_M1:
                begin
                    alt_reg   <= sat32(ACC_W'(alt_reg) + prod_sh);
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    spd_reg   <= sat32(ACC_W'(spd_reg) + prod_sh);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    naa_reg   <= sat32(prod_sh);
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    nas_reg   <= sat32(prod_sh);
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    nsa_reg   <= sat32(ACC_W'(sa_reg) - prod_sh);
                    state_reg <= S_M6;
                end
                S_M6:
                begin
                    ss_reg  <= sat32(ACC_W'(ss_reg) - prod_sh);
                    aa_reg  <= naa_reg;
                    as_reg  <= nas_reg;
                    sa_reg  <= nsa_reg;
                    cnt_reg <= cnt_n;
                    if (cnt_n > CNT_W'(MIN_UPDATES) && naa_reg < 32'(ONE_FX)) begin
                        conv_reg <= 1'b1;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_reg <= in_data;
        end
        if (out_load) begin
            out_reg.altitude          <= alt_reg;
            out_reg.speed             <= spd_reg;
            out_reg.innovation        <= innov_reg;
            out_reg.altitude_variance <= aa_reg;
            out_reg.speed_variance    <= ss_reg;
            out_reg.converged         <= conv_reg;
            out_reg.status            <= status_reg;
        end
    end

endmodule
`default_nettype wire
